### sv/mfp_pkg.sv
package mfp_pkg;

    // Limb and operand geometry of the 256 x 256 multiplier.
    localparam int LIMB_W        = 32;
    localparam int OPERAND_LIMBS = 8;
    localparam int OPERAND_W     = LIMB_W * OPERAND_LIMBS;
    localparam int PRODUCT_W     = 2 * OPERAND_W;
    localparam int HALF_W        = PRODUCT_W / 2;
    localparam int WORD_W        = 64;
    localparam int IN_WORDS      = OPERAND_W / WORD_W;
    localparam int OUT_WORDS     = PRODUCT_W / WORD_W;

    typedef logic [LIMB_W-1:0]     limb_t;
    typedef logic [2*LIMB_W-1:0]   limb_prod_t;
    typedef logic [OPERAND_W-1:0]  operand_t;
    typedef logic [PRODUCT_W-1:0]  product_t;
    typedef logic [HALF_W-1:0]     half_t;

    // Payload handed from one cell to the next. The running sum of the partial
    // products is kept in carry-save form (sum and carry vectors).
    typedef struct packed {
        operand_t a;
        operand_t b;
        product_t sum;
        product_t carry;
    } cell_bus_t;

    // Full 32 x 32 -> 64 bit product of two limbs.
    function automatic limb_prod_t mul_limbs(input limb_t x, input limb_t y);
        limb_prod_t xe;
        limb_prod_t ye;
        xe = limb_prod_t'(x);
        ye = limb_prod_t'(y);
        return xe * ye;
    endfunction

endpackage

### sv/mfp_cell.sv
module mfp_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  mfp_pkg::cell_bus_t in_bus,
    output logic              out_valid,
    output mfp_pkg::cell_bus_t out_bus
);

    // Stage one: the eight limb products of a[CELL_INDEX] with every limb of b.
    logic                  valid_s1_reg;
    mfp_pkg::cell_bus_t    bus_s1_reg;
    mfp_pkg::limb_prod_t   pp_reg  [mfp_pkg::OPERAND_LIMBS];
    mfp_pkg::limb_prod_t   pp_next [mfp_pkg::OPERAND_LIMBS];
    mfp_pkg::limb_t        a_limb;

    // Stage two: the row is folded into the carry-save sum.
    logic                  valid_s2_reg;
    mfp_pkg::cell_bus_t    bus_s2_reg;
    mfp_pkg::cell_bus_t    bus_s2_next;
    mfp_pkg::product_t     even_row;
    mfp_pkg::product_t     odd_row;
    mfp_pkg::product_t     s1;
    mfp_pkg::product_t     c1;

    assign a_limb = in_bus.a[CELL_INDEX*mfp_pkg::LIMB_W +: mfp_pkg::LIMB_W];

    always_comb
    begin
        for (int j = 0; j < mfp_pkg::OPERAND_LIMBS; j++)
        begin
            pp_next[j] = mfp_pkg::mul_limbs(a_limb,
                             in_bus.b[j*mfp_pkg::LIMB_W +: mfp_pkg::LIMB_W]);
        end
    end

    // Products of even limbs of b do not overlap one another, nor do those of
    // odd limbs, so the whole row is just two concatenations.
    always_comb
    begin
        even_row = '0;
        odd_row  = '0;
        for (int j = 0; j < mfp_pkg::OPERAND_LIMBS; j++)
        begin
            if ((j % 2) == 0)
            begin
                even_row[(CELL_INDEX + j)*mfp_pkg::LIMB_W +: 2*mfp_pkg::LIMB_W] = pp_reg[j];
            end
            else
            begin
                odd_row[(CELL_INDEX + j)*mfp_pkg::LIMB_W +: 2*mfp_pkg::LIMB_W] = pp_reg[j];
            end
        end
    end

    // Two rows of full adders: a 4:2 compression with no carry propagation.
    always_comb
    begin
        s1 = bus_s1_reg.sum ^ bus_s1_reg.carry ^ even_row;
        c1 = ((bus_s1_reg.sum & bus_s1_reg.carry) | (bus_s1_reg.sum & even_row)
              | (bus_s1_reg.carry & even_row)) << 1;
        bus_s2_next       = bus_s1_reg;
        bus_s2_next.sum   = s1 ^ c1 ^ odd_row;
        bus_s2_next.carry = ((s1 & c1) | (s1 & odd_row) | (c1 & odd_row)) << 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_s1_reg <= in_valid;
            valid_s2_reg <= valid_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bus_s1_reg <= in_bus;
            for (int j = 0; j < mfp_pkg::OPERAND_LIMBS; j++)
            begin
                pp_reg[j] <= pp_next[j];
            end
            bus_s2_reg <= bus_s2_next;
        end
    end

    assign out_valid = valid_s2_reg;
    assign out_bus   = bus_s2_reg;

endmodule

### sv/mfp_final_add.sv
module mfp_final_add (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  mfp_pkg::cell_bus_t in_bus,
    output logic               out_valid,
    output mfp_pkg::product_t  product
);

    // The carry-save pair is resolved in two halves, the low half first.
    logic                valid_lo_reg;
    mfp_pkg::half_t      low_reg;
    logic                low_cout_reg;
    mfp_pkg::half_t      hi_sum_reg;
    mfp_pkg::half_t      hi_carry_reg;
    logic [mfp_pkg::HALF_W:0] low_next;

    logic                valid_out_reg;
    mfp_pkg::product_t   product_reg;
    mfp_pkg::half_t      high_next;

    assign low_next = {1'b0, in_bus.sum[mfp_pkg::HALF_W-1:0]}
                    + {1'b0, in_bus.carry[mfp_pkg::HALF_W-1:0]};

    assign high_next = hi_sum_reg + hi_carry_reg + mfp_pkg::half_t'(low_cout_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_lo_reg  <= 1'b0;
            valid_out_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_lo_reg  <= in_valid;
            valid_out_reg <= valid_lo_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            low_reg      <= low_next[mfp_pkg::HALF_W-1:0];
            low_cout_reg <= low_next[mfp_pkg::HALF_W];
            hi_sum_reg   <= in_bus.sum[mfp_pkg::PRODUCT_W-1:mfp_pkg::HALF_W];
            hi_carry_reg <= in_bus.carry[mfp_pkg::PRODUCT_W-1:mfp_pkg::HALF_W];
            product_reg  <= {high_next, low_reg};
        end
    end

    assign out_valid = valid_out_reg;
    assign product   = product_reg;

endmodule

### sv/mul_256x256_full_product.sv
// Unsigned 256 x 256 -> 512 bit multiplier. Each input beat carries both
// operands and each output beat the exact product; there is no state, so
// beats are independent. The datapath is a row of eight identical cells, one
// for each 32-bit limb of operand A: every cell multiplies its limb by all
// eight limbs of B in parallel, registers the eight products, and folds the
// row into a running sum kept in carry-save form, so no carry ever ripples
// inside a cell. A final two-stage adder resolves the carry-save pair into
// the product, low half first. A new beat is accepted every clock cycle
// unless the pipeline is halted. The whole pipeline advances together and
// halts only while the output register holds an untaken beat, so a stall on
// the output side reaches s_axis_tready in the same cycle.
module mul_256x256_full_product (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0 up: a_word_0, a_word_1, a_word_2, a_word_3,
    // b_word_0, b_word_1, b_word_2, b_word_3 (64 bits each).
    input  logic [511:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0 up: product_word_0 .. product_word_7 (64 bits each).
    output logic [511:0] m_axis_tdata
);

    logic                       advance;
    logic [mfp_pkg::OPERAND_LIMBS:0] valid_chain;
    mfp_pkg::cell_bus_t         bus_chain [mfp_pkg::OPERAND_LIMBS+1];
    mfp_pkg::product_t          product;

    // The output register is free, or its beat is being taken this cycle.
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    // Operand A sits in the low half of the input beat, operand B above it.
    // The carry-save sum starts at zero.
    assign valid_chain[0]     = s_axis_tvalid;
    assign bus_chain[0].a     = s_axis_tdata[mfp_pkg::OPERAND_W-1:0];
    assign bus_chain[0].b     = s_axis_tdata[2*mfp_pkg::OPERAND_W-1:mfp_pkg::OPERAND_W];
    assign bus_chain[0].sum   = '0;
    assign bus_chain[0].carry = '0;

    for (genvar i = 0; i < mfp_pkg::OPERAND_LIMBS; i++)
    begin : g_cell
        mfp_cell #(
            .CELL_INDEX(i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .in_valid (valid_chain[i]),
            .in_bus   (bus_chain[i]),
            .out_valid(valid_chain[i+1]),
            .out_bus  (bus_chain[i+1])
        );
    end

    mfp_final_add u_final_add (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (valid_chain[mfp_pkg::OPERAND_LIMBS]),
        .in_bus   (bus_chain[mfp_pkg::OPERAND_LIMBS]),
        .out_valid(m_axis_tvalid),
        .product  (product)
    );

    assign m_axis_tdata = product;

`ifndef NO_ASSERTIONS
    // A beat waiting at the output must hold the input side off.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while the output stage is stalled");

    // While the pipeline is halted no beat may move between cells.
    a_stall_freezes_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_chain[mfp_pkg::OPERAND_LIMBS:1]))
        else $error("cell pipeline moved during a stall");

    // A beat taken at the output frees the pipeline to accept input.
    a_take_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |-> s_axis_tready)
        else $error("input held off although the output beat was taken");
`endif

endmodule

### sim/mfp_product_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels of the multiplier. Each operand pair taken on
// the input side is turned into its expected 512-bit product, and each beat
// leaving the output side is compared word by word with the oldest one.
module mfp_product_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [511:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [511:0] m_axis_tdata,
    output int           mismatch_count,
    output int           pending_count
);

    typedef logic [2*mfp_pkg::IN_WORDS-1:0][mfp_pkg::WORD_W-1:0] operand_words_t;
    typedef logic [mfp_pkg::OUT_WORDS-1:0][mfp_pkg::WORD_W-1:0]  product_words_t;

    localparam int REPORT_LIMIT = 10;

    product_words_t expected_products [$];
    int             results_seen;

    // Limb-by-limb schoolbook multiply: one row per limb of A, with the carry
    // rippled along the row. A 32 x 32 product plus a column limb plus the
    // carry never exceeds 64 bits, so nothing is lost.
    function automatic product_words_t schoolbook_product(input operand_words_t words);
        mfp_pkg::limb_t a_limb [mfp_pkg::OPERAND_LIMBS];
        mfp_pkg::limb_t b_limb [mfp_pkg::OPERAND_LIMBS];
        mfp_pkg::limb_t column [2*mfp_pkg::OPERAND_LIMBS];
        logic [63:0]    acc;
        logic [63:0]    carry;
        product_words_t result;
        for (int k = 0; k < mfp_pkg::OPERAND_LIMBS; k++)
        begin
            a_limb[k] = words[k/2][mfp_pkg::LIMB_W*(k%2) +: mfp_pkg::LIMB_W];
            b_limb[k] = words[mfp_pkg::IN_WORDS + k/2][mfp_pkg::LIMB_W*(k%2) +: mfp_pkg::LIMB_W];
        end
        foreach (column[k])
            column[k] = '0;
        for (int i = 0; i < mfp_pkg::OPERAND_LIMBS; i++)
        begin
            carry = '0;
            for (int j = 0; j < mfp_pkg::OPERAND_LIMBS; j++)
            begin
                acc = 64'(a_limb[i]) * 64'(b_limb[j]) + 64'(column[i+j]) + carry;
                column[i+j] = acc[31:0];
                carry       = {32'd0, acc[63:32]};
            end
            column[i + mfp_pkg::OPERAND_LIMBS] = carry[31:0];
        end
        for (int k = 0; k < mfp_pkg::OUT_WORDS; k++)
            result[k] = {column[2*k+1], column[2*k]};
        return result;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        product_words_t expected;
        product_words_t actual;
        int             errors;
        if (!rst_n)
        begin
            expected_products.delete();
            results_seen   = 0;
            errors         = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            errors = mismatch_count;
            // The output side is handled first: a pair accepted now cannot
            // have its product leaving in the same cycle.
            if (m_axis_tvalid && m_axis_tready)
            begin
                actual = m_axis_tdata;
                if (expected_products.size() == 0)
                begin
                    if (errors < REPORT_LIMIT)
                        $display("product beat %0d arrived with nothing expected: %h",
                                 results_seen, actual);
                    errors++;
                end
                else
                begin
                    expected = expected_products.pop_front();
                    if (actual != expected)
                    begin
                        if (errors < REPORT_LIMIT)
                            for (int k = 0; k < mfp_pkg::OUT_WORDS; k++)
                                if (actual[k] != expected[k])
                                    $display("product beat %0d word %0d: expected %h, got %h",
                                             results_seen, k, expected[k], actual[k]);
                        errors++;
                    end
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_products.push_back(schoolbook_product(s_axis_tdata));
            mismatch_count <= errors;
            pending_count  <= expected_products.size();
        end
    end

endmodule

### sim/tb_mul_256x256_full_product.sv
`timescale 1ns / 100ps

// Top of the multiplier testbench. It makes the clock and the single reset,
// feeds operand pairs in bursts, throttles the product side on a pattern of
// its own, and gives the verdict. All prediction and comparison is left to
// the checker instance that sits beside the block.
module tb_mul_256x256_full_product;

    typedef mfp_pkg::operand_t operand_t;

    // Number of random operand pairs after the directed ones.
    localparam int RANDOM_PAIRS  = 1900;
    // Extra wait after the last product; a comfortable margin on the pipeline depth.
    localparam int DRAIN_CYCLES  = 60;
    // Watchdog limit, set with a wide margin over a run with the slowest
    // receiver phase and the longest sender gaps.
    localparam int CYCLE_LIMIT   = 400000;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // Fields from bit 0 up: a_word_0 .. a_word_3, b_word_0 .. b_word_3.
    logic [511:0] s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // Fields from bit 0 up: product_word_0 .. product_word_7.
    logic [511:0] m_axis_tdata;

    int           mismatch_count;
    int           pending_count;
    int           cycle_count   = 0;

    logic [511:0] operand_pairs [$];

    mul_256x256_full_product u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mfp_product_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle counter and watchdog. Should the block stop moving beats, the run
    // is ended here rather than hanging.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The product side cycles through four phases in turn: always ready,
    // mostly ready, mostly stalled, and a stall pattern that repeats at a fixed
    // place. Back-pressure therefore lands on every stage of the pipeline, and
    // there are long stretches with none at all.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            case (cycle_count[9:8])
                2'd0:    m_axis_tready <= 1'b1;
                2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
                2'd2:    m_axis_tready <= ($urandom_range(0, 9) < 3);
                default: m_axis_tready <= (cycle_count[3:0] < 4'd11);
            endcase
    end

    // One random 64-bit word in the given flavour. Plain random words cover
    // every bit; the other flavours push the carry chains and the zero paths.
    function automatic logic [63:0] random_word(input int flavour);
        logic [63:0] word;
        word = {$urandom(), $urandom()};
        case (flavour)
            // Carry-heavy: each limb is either all ones or random.
            1:
            begin
                if ($urandom_range(0, 1) == 0)
                    word[31:0] = '1;
                if ($urandom_range(0, 1) == 0)
                    word[63:32] = '1;
            end
            // Sparse: whole words often zero.
            2:
                if ($urandom_range(0, 1) == 0)
                    word = '0;
            // Extremes of the word range.
            3:
                case ($urandom_range(0, 4))
                    0:       word = '0;
                    1:       word = 64'd1;
                    2:       word = '1;
                    3:       word = 64'h8000_0000_0000_0000;
                    default: word = word;
                endcase
            default: word = word;
        endcase
        return word;
    endfunction

    function automatic operand_t random_operand(input int flavour);
        operand_t value;
        for (int k = 0; k < mfp_pkg::IN_WORDS; k++)
            value[64*k +: 64] = random_word(flavour);
        return value;
    endfunction

    // Operand A sits in the low half of the beat, B in the high half.
    task automatic queue_pair(input operand_t a, input operand_t b);
        operand_pairs.push_back({b, a});
    endtask

    initial
    begin
        operand_t all_ones;
        operand_t top_bit;
        operand_t single_limb;
        int       flavour;
        int       burst_left;
        int       gap;
        logic [511:0] beat;

        all_ones = '1;
        top_bit  = '0;
        top_bit[mfp_pkg::OPERAND_W-1] = 1'b1;

        // Directed pairs: zero on either side, all ones squared (the widest
        // column sums, where a lost carry would show), unit factors, the top
        // bit squared, and each limb alone at all ones against a full B.
        queue_pair('0, '0);
        queue_pair('0, all_ones);
        queue_pair(all_ones, '0);
        queue_pair(all_ones, all_ones);
        queue_pair(operand_t'(1), operand_t'(1));
        queue_pair(operand_t'(1), all_ones);
        queue_pair(all_ones, operand_t'(1));
        queue_pair(top_bit, top_bit);
        queue_pair(top_bit, all_ones);
        for (int k = 0; k < mfp_pkg::OPERAND_LIMBS; k++)
        begin
            single_limb = '0;
            single_limb[mfp_pkg::LIMB_W*k +: mfp_pkg::LIMB_W] = '1;
            queue_pair(single_limb, all_ones);
        end
        queue_pair({64{4'hA}}, {64{4'h5}});
        queue_pair({64{4'h5}}, {64{4'hA}});
        queue_pair({4{64'h0000_0000_FFFF_FFFF}}, {4{64'h0000_0000_FFFF_FFFF}});
        queue_pair({4{64'hFFFF_FFFF_0000_0000}}, {4{64'hFFFF_FFFF_0000_0000}});

        // Random pairs, half uniform, the rest biased towards long carry
        // chains, zero words and extreme values.
        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: flavour = 0;
                5, 6:          flavour = 1;
                7, 8:          flavour = 2;
                default:       flavour = 3;
            endcase
            queue_pair(random_operand(flavour), random_operand(flavour));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The sender moves pairs in bursts. A gap of zero merges two bursts
        // into one longer run, which gives stretches at full rate.
        burst_left = $urandom_range(1, 24);
        while (operand_pairs.size() != 0)
        begin
            beat = operand_pairs.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= beat;
            do
                @(posedge clk);
            while (!s_axis_tready);
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // Wait for every product, then a little longer so that any stray
        // beat from the block is still caught by the checker.
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
